/* design/cdp_pkg.sv */
// Shared constants and types for the periodic cross-distance block.
package cdp_pkg;

  // Fixed field widths
  localparam int PERIOD_BITS   = 23;
  localparam int DIST_BITS     = 52;
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  // Register indexes on the configuration port (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_PERIODIC = 2'd0,
    REG_SQUARED  = 2'd1,
    REG_PWIDTH   = 2'd2,
    REG_PHEIGHT  = 2'd3
  } reg_idx_e;

  // Configuration register set
  typedef struct packed {
    logic                   periodic;
    logic                   squared;
    logic [PERIOD_BITS-1:0] pwidth;
    logic [PERIOD_BITS-1:0] pheight;
  } cfg_t;

endpackage

/* design/cdp_pair_if.sv */
// Point-pair input channel: valid/ready handshake with two coordinate pairs.
interface cdp_pair_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] from_x;
  logic signed [COORD_BITS-1:0] from_y;
  logic signed [COORD_BITS-1:0] to_x;
  logic signed [COORD_BITS-1:0] to_y;

  modport source (output valid, output from_x, output from_y, output to_x, output to_y,
                  input ready);
  modport sink   (input valid, input from_x, input from_y, input to_x, input to_y,
                  output ready);
endinterface

/* design/cdp_dist_if.sv */
// Distance result channel: valid/ready handshake with one distance word.
interface cdp_dist_if;
  logic                          valid;
  logic                          ready;
  logic [cdp_pkg::DIST_BITS-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

/* design/cdp_front.sv */
// Front pipeline: axis differences, wrap candidates, minimum magnitude, squares and sum.
module cdp_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cdp_pkg::cfg_t                cfg_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] from_x_i,
  input  logic signed [COORD_BITS-1:0] from_y_i,
  input  logic signed [COORD_BITS-1:0] to_x_i,
  input  logic signed [COORD_BITS-1:0] to_y_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [2*(((COORD_BITS + 1 > cdp_pkg::PERIOD_BITS + 1) ? COORD_BITS + 1 :
                  cdp_pkg::PERIOD_BITS + 1) + 1):0] sum_o
);

  // Axis word: holds d, d - P and d + P without overflow
  localparam int AXIS_BITS = ((COORD_BITS + 1 > cdp_pkg::PERIOD_BITS + 1) ? COORD_BITS + 1 :
                              cdp_pkg::PERIOD_BITS + 1) + 1;
  localparam int SQ_BITS   = 2 * AXIS_BITS;
  localparam int SUM_BITS  = SQ_BITS + 1;
  localparam int NSTAGE    = 6;

  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE:0]   rdy;
  logic [NSTAGE-1:0] ld;

  logic signed [COORD_BITS-1:0] from_c [2];
  logic signed [COORD_BITS-1:0] to_c   [2];
  logic        [AXIS_BITS-1:0]  per_c  [2];

  logic signed [AXIS_BITS-1:0] d_q    [2];
  logic signed [AXIS_BITS-1:0] cand_q [2][3];
  logic        [AXIS_BITS-1:0] mag_q  [2][3];
  logic        [AXIS_BITS-1:0] min_q  [2];
  logic        [SQ_BITS-1:0]   sq_q   [2];
  logic        [SUM_BITS-1:0]  sum_q;

  logic        [AXIS_BITS-1:0] mag_d  [2][3];
  logic        [AXIS_BITS-1:0] min_d  [2];
  logic        [AXIS_BITS-1:0] min01  [2];

  // Stage handshake: a stage takes new data when empty or when it drains
  always_comb begin
    rdy[NSTAGE] = ready_i;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && valid_i;
    for (int k = 1; k < NSTAGE; k++) begin
      ld[k] = rdy[k] && v_q[k-1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NSTAGE-1];
  assign sum_o   = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Lane inputs; a zero period makes all three candidates equal
  always_comb begin
    from_c[0] = from_x_i;
    from_c[1] = from_y_i;
    to_c[0]   = to_x_i;
    to_c[1]   = to_y_i;
    per_c[0]  = cfg_i.periodic ? AXIS_BITS'(cfg_i.pwidth)  : '0;
    per_c[1]  = cfg_i.periodic ? AXIS_BITS'(cfg_i.pheight) : '0;
  end

  // Magnitudes and the smallest candidate per axis
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int c = 0; c < 3; c++) begin
        mag_d[a][c] = cand_q[a][c][AXIS_BITS-1] ? (~$unsigned(cand_q[a][c]) + AXIS_BITS'(1))
                                                  : $unsigned(cand_q[a][c]);
      end
      min01[a] = (mag_q[a][1] < mag_q[a][0]) ? mag_q[a][1] : mag_q[a][0];
      min_d[a] = (mag_q[a][2] < min01[a]) ? mag_q[a][2] : min01[a];
    end
  end

  // Datapath registers, one stage per step
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      if (ld[0]) begin
        d_q[a] <= AXIS_BITS'(to_c[a]) - AXIS_BITS'(from_c[a]);
      end
      if (ld[1]) begin
        cand_q[a][0] <= d_q[a];
        cand_q[a][1] <= d_q[a] - $signed(per_c[a]);
        cand_q[a][2] <= d_q[a] + $signed(per_c[a]);
      end
      if (ld[2]) begin
        mag_q[a] <= mag_d[a];
      end
      if (ld[3]) begin
        min_q[a] <= min_d[a];
      end
      if (ld[4]) begin
        sq_q[a] <= SQ_BITS'(min_q[a] * min_q[a]);
      end
    end
    if (ld[5]) begin
      sum_q <= SUM_BITS'(sq_q[0]) + SUM_BITS'(sq_q[1]);
    end
  end

endmodule

/* design/cdp_root_cell.sv */
// Square-root cell: settles one root bit per stage, passes the sum through in squared mode.
module cdp_root_cell #(
  parameter int SUM_BITS = 53,
  parameter int BIT_POS  = 52
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                squared_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [SUM_BITS-1:0] rem_i,
  input  logic [SUM_BITS-1:0] root_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [SUM_BITS-1:0] rem_o,
  output logic [SUM_BITS-1:0] root_o
);

  localparam logic [SUM_BITS-1:0] BIT_VAL = SUM_BITS'(1) << BIT_POS;

  logic                v_q;
  logic [SUM_BITS-1:0] rem_q, rem_d;
  logic [SUM_BITS-1:0] root_q, root_d;
  logic [SUM_BITS-1:0] trial;
  logic                take;

  // Trial subtraction for this bit
  always_comb begin
    trial  = root_i + BIT_VAL;
    take   = rem_i >= trial;
    rem_d  = (take && !squared_i) ? rem_i - trial : rem_i;
    root_d = take ? (root_i >> 1) + BIT_VAL : root_i >> 1;
  end

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

endmodule

/* design/cross_distance_periodic.sv */
// Top level of the periodic cross-distance block: register port, pipeline and result stage.
//
// Usage:
//   pair_i  (sink)   : one point pair per transfer, signed coordinates, 12 fraction bits.
//   dist_o  (source) : one distance per pair, in input order; squared distance with
//                      24 fraction bits, or its truncated root with 12 fraction bits.
//   APB port         : four registers at byte addresses 0, 4, 8, 12 (periodic enable,
//                      squared mode, period along x, period along y); write only while idle.
// Throughput: one pair per cycle while dist_o.ready is high. Every stage holds its own
//   valid bit and takes new data when empty or draining, so bubbles close up and a pair
//   is accepted while a result waits at the output.
// Pipeline: 6 front stages, then (AXIS_BITS + 1) root cells, then 1 output stage;
//   the root cell chain is its longest part.
// Reset: all valid bits and the configuration registers clear; no result is pending afterwards.
// Stall: when dist_o.ready is low the result holds, the chain fills up behind it and
//   pair_i.ready drops only once every stage is occupied.
module cross_distance_periodic #(
  parameter int COORD_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  cdp_pair_if.sink                           pair_i,
  cdp_dist_if.source                         dist_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cdp_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [cdp_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [cdp_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  localparam int AXIS_BITS = ((COORD_BITS + 1 > cdp_pkg::PERIOD_BITS + 1) ? COORD_BITS + 1 :
                              cdp_pkg::PERIOD_BITS + 1) + 1;
  localparam int SUM_BITS  = 2 * AXIS_BITS + 1;
  localparam int NCELL     = AXIS_BITS + 1;

  cdp_pkg::cfg_t     cfg_q;
  cdp_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  // Register port: zero wait states
  assign pready  = 1'b1;
  assign reg_idx = cdp_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        cdp_pkg::REG_PERIODIC: cfg_q.periodic <= pwdata[0];
        cdp_pkg::REG_SQUARED:  cfg_q.squared  <= pwdata[0];
        cdp_pkg::REG_PWIDTH:   cfg_q.pwidth   <= pwdata[cdp_pkg::PERIOD_BITS-1:0];
        cdp_pkg::REG_PHEIGHT:  cfg_q.pheight  <= pwdata[cdp_pkg::PERIOD_BITS-1:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      cdp_pkg::REG_PERIODIC: prdata = cdp_pkg::APB_DATA_BITS'(cfg_q.periodic);
      cdp_pkg::REG_SQUARED:  prdata = cdp_pkg::APB_DATA_BITS'(cfg_q.squared);
      cdp_pkg::REG_PWIDTH:   prdata = cdp_pkg::APB_DATA_BITS'(cfg_q.pwidth);
      cdp_pkg::REG_PHEIGHT:  prdata = cdp_pkg::APB_DATA_BITS'(cfg_q.pheight);
    endcase
  end

  // Chain links: index 0 is the front pipeline, NCELL the last root cell
  logic                cv   [NCELL+1];
  logic                cr   [NCELL+1];
  logic [SUM_BITS-1:0] rem  [NCELL+1];
  logic [SUM_BITS-1:0] root [NCELL+1];

  cdp_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (pair_i.valid),
    .ready_o (pair_i.ready),
    .from_x_i(pair_i.from_x),
    .from_y_i(pair_i.from_y),
    .to_x_i  (pair_i.to_x),
    .to_y_i  (pair_i.to_y),
    .valid_o (cv[0]),
    .ready_i (cr[0]),
    .sum_o   (rem[0])
  );

  assign root[0] = '0;

  // Root cells, most significant bit first
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    cdp_root_cell #(
      .SUM_BITS(SUM_BITS),
      .BIT_POS (2 * (NCELL - 1 - j))
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .squared_i(cfg_q.squared),
      .valid_i  (cv[j]),
      .ready_o  (cr[j]),
      .rem_i    (rem[j]),
      .root_i   (root[j]),
      .valid_o  (cv[j+1]),
      .ready_i  (cr[j+1]),
      .rem_o    (rem[j+1]),
      .root_o   (root[j+1])
    );
  end

  // Result stage: saturated sum or root
  logic                          out_v_q;
  logic [cdp_pkg::DIST_BITS-1:0] dist_q, dist_d;
  logic                          sat;

  assign cr[NCELL] = !out_v_q || dist_o.ready;
  assign sat       = |(rem[NCELL] >> cdp_pkg::DIST_BITS);

  always_comb begin
    if (cfg_q.squared) begin
      dist_d = sat ? '1 : rem[NCELL][cdp_pkg::DIST_BITS-1:0];
    end else begin
      dist_d = root[NCELL][cdp_pkg::DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cr[NCELL]) begin
      out_v_q <= cv[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cr[NCELL] && cv[NCELL]) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o.valid    = out_v_q;
  assign dist_o.distance = dist_q;

  // Input back-pressure only arises once the result stage is full
  a_stall_needs_full_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pair_i.ready |-> dist_o.valid)
    else $error("input stalled while result stage empty");

  // A root result never exceeds AXIS_BITS + 1 bits
  a_root_width : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_o.valid && !cfg_q.squared) |-> ((dist_o.distance >> (AXIS_BITS + 1)) == '0))
    else $error("root result wider than expected");

  // The result stage fills only from a valid last cell
  a_out_from_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(cv[NCELL]))
    else $error("result appeared without a finished root cell");

endmodule

/* sim/cross_distance_periodic_tb.sv */
// Self-checking testbench for the periodic cross-distance block.
module cross_distance_periodic_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS   = 24;
  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_CYCLES  = 300;
  localparam int SEGMENTS     = 8;
  localparam int SEG_PAIRS    = 230;
  localparam longint CMAX     = 64'sd8388607;
  localparam longint CMIN     = -64'sd8388608;
  localparam logic [31:0] PMAX = 32'd8388607;

  typedef struct {
    logic signed [COORD_BITS-1:0] from_x;
    logic signed [COORD_BITS-1:0] from_y;
    logic signed [COORD_BITS-1:0] to_x;
    logic signed [COORD_BITS-1:0] to_y;
  } pair_t;

  // Register copy, distance predictor and queue of pending distances
  class dist_scoreboard;
    cdp_pkg::cfg_t                 cfg;
    logic [cdp_pkg::DIST_BITS-1:0] pending_dist[$];
    int                            errors;
    int                            pairs_seen;
    int                            results_seen;

    function new();
      cfg          = '0;
      errors       = 0;
      pairs_seen   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(cdp_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        cdp_pkg::REG_PERIODIC: cfg.periodic = value[0];
        cdp_pkg::REG_SQUARED:  cfg.squared  = value[0];
        cdp_pkg::REG_PWIDTH:   cfg.pwidth   = value[cdp_pkg::PERIOD_BITS-1:0];
        cdp_pkg::REG_PHEIGHT:  cfg.pheight  = value[cdp_pkg::PERIOD_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned sq_mag(longint v);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      return m * m;
    endfunction

    // Smallest square over the plain difference and one wrap either way
    function longint unsigned axis_sq(longint d, longint period);
      longint unsigned best;
      longint unsigned alt;
      best = sq_mag(d);
      if (cfg.periodic) begin
        alt = sq_mag(d - period);
        if (alt < best) best = alt;
        alt = sq_mag(d + period);
        if (alt < best) best = alt;
      end
      return best;
    endfunction

    // Truncated square root, one result bit at a time from the top
    function longint unsigned floor_root(longint unsigned n);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= n) r = trial;
      end
      return r;
    endfunction

    function void note_pair(pair_t p);
      longint          dx;
      longint          dy;
      longint unsigned sum;
      longint unsigned dmax;
      dmax = (64'd1 << cdp_pkg::DIST_BITS) - 1;
      dx   = longint'(p.to_x) - longint'(p.from_x);
      dy   = longint'(p.to_y) - longint'(p.from_y);
      sum  = axis_sq(dx, longint'(cfg.pwidth)) + axis_sq(dy, longint'(cfg.pheight));
      if (cfg.squared) begin
        if (sum > dmax) sum = dmax;
      end else begin
        sum = floor_root(sum);
      end
      pending_dist.push_back(sum[cdp_pkg::DIST_BITS-1:0]);
      pairs_seen++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_distance(logic [cdp_pkg::DIST_BITS-1:0] got);
      logic [cdp_pkg::DIST_BITS-1:0] want;
      if (pending_dist.size() == 0) begin
        report($sformatf("distance %0d arrived with nothing pending", got));
      end else begin
        want = pending_dist.pop_front();
        if (got !== want)
          report($sformatf("result %0d: distance %0d, predicted %0d",
                           results_seen, got, want));
      end
      results_seen++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [cdp_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [cdp_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [cdp_pkg::APB_DATA_BITS-1:0] prdata;
  logic pready;

  cdp_pair_if #(.COORD_BITS(COORD_BITS)) pair_bus ();
  cdp_dist_if dist_bus ();

  dist_scoreboard sb = new();

  int gap_pct;
  int stall_pct;
  int hold_left;
  int settings_applied;

  cross_distance_periodic #(.COORD_BITS(COORD_BITS)) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pair_i  (pair_bus),
    .dist_o  (dist_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Overall time limit
  initial begin
    #3ms;
    $display("TIMEOUT: run did not finish");
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: check each transfer, then pick the next ready level
  initial begin
    dist_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && dist_bus.valid && dist_bus.ready) sb.check_distance(dist_bus.distance);
      if (hold_left > 0) begin
        dist_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        dist_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one pair, with random idle cycles first, until it transfers
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < gap_pct) begin
      pair_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    pair_bus.valid  <= 1'b1;
    pair_bus.from_x <= p.from_x;
    pair_bus.from_y <= p.from_y;
    pair_bus.to_x   <= p.to_x;
    pair_bus.to_y   <= p.to_y;
    do @(posedge clk_i); while (!pair_bus.ready);
    sb.note_pair(p);
  endtask

  task automatic send_xy(longint fx, longint fy, longint tx, longint ty);
    pair_t p;
    p.from_x = COORD_BITS'(fx);
    p.from_y = COORD_BITS'(fy);
    p.to_x   = COORD_BITS'(tx);
    p.to_y   = COORD_BITS'(ty);
    send_pair(p);
  endtask

  task automatic wait_idle();
    while (sb.pending_dist.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready, then the bus returns to idle
  task automatic apb_write(cdp_pkg::reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [31:0] per, logic [31:0] sqr,
                               logic [31:0] pw, logic [31:0] ph);
    pair_bus.valid <= 1'b0;
    wait_idle();
    apb_write(cdp_pkg::REG_PERIODIC, per);
    apb_write(cdp_pkg::REG_SQUARED, sqr);
    apb_write(cdp_pkg::REG_PWIDTH, pw);
    apb_write(cdp_pkg::REG_PHEIGHT, ph);
    settings_applied++;
  endtask

  // Offset that lands near a wrap decision for the given period
  function automatic longint wrap_offset(longint period);
    longint jitter;
    jitter = longint'($urandom_range(0, 16)) - 8;
    case ($urandom_range(5))
      0: return period / 2 + jitter;
      1: return -(period / 2) + jitter;
      2: return period + jitter;
      3: return -period + jitter;
      4: return longint'($urandom_range(0, 2 * period + 2)) - period - 1;
      default: return 2 * period + jitter;
    endcase
  endfunction

  function automatic longint pick_extreme();
    case ($urandom_range(4))
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic pair_t make_pair();
    pair_t  p;
    int     kind;
    longint span;
    p.from_x = COORD_BITS'($urandom);
    p.from_y = COORD_BITS'($urandom);
    p.to_x   = COORD_BITS'($urandom);
    p.to_y   = COORD_BITS'($urandom);
    kind     = $urandom_range(99);
    if (kind >= 40 && kind < 65) begin
      // neighbouring points
      span   = longint'(1) << $urandom_range(0, 20);
      p.to_x = COORD_BITS'(longint'(p.from_x) + longint'($urandom_range(0, 2 * span)) - span);
      p.to_y = COORD_BITS'(longint'(p.from_y) + longint'($urandom_range(0, 2 * span)) - span);
    end else if (kind >= 65 && kind < 90) begin
      // differences around the wrap thresholds
      p.to_x = COORD_BITS'(longint'(p.from_x) + wrap_offset(longint'(sb.cfg.pwidth)));
      p.to_y = COORD_BITS'(longint'(p.from_y) + wrap_offset(longint'(sb.cfg.pheight)));
    end else if (kind >= 90) begin
      p.from_x = COORD_BITS'(pick_extreme());
      p.from_y = COORD_BITS'(pick_extreme());
      p.to_x   = COORD_BITS'(pick_extreme());
      p.to_y   = COORD_BITS'(pick_extreme());
    end
    return p;
  endfunction

  // Stimulus
  initial begin
    logic [31:0] per;
    logic [31:0] sqr;
    logic [31:0] pw;
    logic [31:0] ph;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    pair_bus.valid   = 1'b0;
    pair_bus.from_x  = '0;
    pair_bus.from_y  = '0;
    pair_bus.to_x    = '0;
    pair_bus.to_y    = '0;
    gap_pct          = 0;
    stall_pct        = 0;
    hold_left        = 0;
    settings_applied = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Plain root, no wrap: zero, full span both ways, 3-4-5, one LSB
    apply_setting(32'd0, 32'd0, 32'd0, 32'd0);
    send_xy(0, 0, 0, 0);
    send_xy(CMIN, CMIN, CMAX, CMAX);
    send_xy(CMAX, CMAX, CMIN, CMIN);
    send_xy(0, 0, 3 * 4096, 4 * 4096);
    send_xy(0, 0, -1, -1);

    // Zero period in periodic mode gives the plain distance
    apply_setting(32'd1, 32'd1, 32'd0, 32'd0);
    send_xy(CMIN, CMAX, CMAX, CMIN);
    send_xy(100, -200, -300, 400);
    send_xy(0, 0, 1, 0);

    // Largest periods, differences either side of half a period
    apply_setting(32'd1, 32'd0, PMAX, PMAX);
    send_xy(0, 0, 4194303, 4194304);
    send_xy(0, 0, -4194304, -4194303);
    send_xy(CMIN, CMIN, CMAX, CMAX);
    send_xy(CMAX, CMIN, CMIN, CMAX);
    send_xy(0, 0, PMAX, PMAX);

    // Register values beyond their width: only the low bits count
    apply_setting(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFF80_1000, 32'hFFFF_FFFF);
    send_xy(0, 0, 3000, 5000);
    send_xy(CMIN, 0, CMAX, 0);
    apply_setting(32'd1, 32'd0, 32'hFF80_1000, 32'hFFFF_FFFF);
    send_xy(0, 0, 3000, -5000);
    send_xy(0, 0, 8192, 4096);

    // Random segments, each with its own setting and one of four idling modes
    for (int s = 0; s < SEGMENTS; s++) begin
      per = 32'd1;
      sqr = 32'(s % 2);
      pw  = $urandom_range(0, PMAX);
      ph  = $urandom_range(0, PMAX);
      case (s)
        1: begin
          pw = PMAX;
          ph = PMAX;
        end
        2: per = 32'd0;
        3: begin
          pw = $urandom_range(0, 16384);
          ph = $urandom_range(0, 16384);
        end
        4: pw = 32'd0;
        5: per = 32'd0;
        6: begin
          pw = 32'd1;
          ph = PMAX;
        end
        7: begin
          pw = $urandom;
          ph = $urandom;
        end
        default: ;
      endcase
      apply_setting(per, sqr, pw, ph);
      case (s % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 45;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 45;
        end
        default: begin
          gap_pct   = 14;
          stall_pct = 14;
        end
      endcase
      for (int i = 0; i < SEG_PAIRS; i++) begin
        // long output hold while pairs keep coming, so the pipe backs up
        if (s == 0 && i == 60) hold_left = HOLD_CYCLES;
        // sender waits for every pending distance
        if (s == 1 && i == 100) begin
          pair_bus.valid <= 1'b0;
          while (sb.pending_dist.size() != 0) @(posedge clk_i);
        end
        send_pair(make_pair());
      end
    end

    pair_bus.valid <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    wait_idle();

    $display("Covered %0d point pairs and %0d distances over %0d register settings,",
             sb.pairs_seen, sb.results_seen, settings_applied);
    $display("with idle and stall phases and a %0d-cycle output hold.", HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
